@@ sv/owik_pkg.sv @@
// Shared constants, types and tables for the omni wheel inverse kinematics block.
`timescale 1ns / 1ps
package owik_pkg;

  localparam int TRIG_BITS    = 14;
  localparam int CORDIC_STEPS = 30;
  localparam int XW           = 34;
  localparam int ZW           = 34;
  localparam int TW           = TRIG_BITS + 2;
  localparam int CA_W         = TRIG_BITS + 18;
  localparam int NX_W         = 21;
  localparam int LP_W         = 33;
  localparam int P1_W         = NX_W + CA_W;
  localparam int ACC_W        = TRIG_BITS + 42;
  localparam int DW           = ACC_W - (TRIG_BITS + 16);

  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
  localparam logic signed [XW-1:0] TRIG_RND    = XW'(1) <<< (29 - TRIG_BITS);
  localparam logic signed [CA_W-1:0] GEO_ROOT  = CA_W'(56756);
  localparam logic [15:0] LEVER_RESET          = 16'd256;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] spin;
  } cmd_t;

  typedef struct packed {
    logic signed [TW-1:0] cs;
    logic signed [TW-1:0] sn;
  } trig_t;

  function automatic logic signed [ZW-1:0] arc_step(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = ZW'(536870912);
      5'd1:  r = ZW'(316933406);
      5'd2:  r = ZW'(167458907);
      5'd3:  r = ZW'(85004756);
      5'd4:  r = ZW'(42667331);
      5'd5:  r = ZW'(21354465);
      5'd6:  r = ZW'(10679838);
      5'd7:  r = ZW'(5340245);
      5'd8:  r = ZW'(2670163);
      5'd9:  r = ZW'(1335087);
      5'd10: r = ZW'(667544);
      5'd11: r = ZW'(333772);
      5'd12: r = ZW'(166886);
      5'd13: r = ZW'(83443);
      5'd14: r = ZW'(41722);
      5'd15: r = ZW'(20861);
      5'd16: r = ZW'(10430);
      5'd17: r = ZW'(5215);
      5'd18: r = ZW'(2608);
      5'd19: r = ZW'(1304);
      5'd20: r = ZW'(652);
      5'd21: r = ZW'(326);
      5'd22: r = ZW'(163);
      5'd23: r = ZW'(81);
      5'd24: r = ZW'(41);
      5'd25: r = ZW'(20);
      5'd26: r = ZW'(10);
      5'd27: r = ZW'(5);
      5'd28: r = ZW'(3);
      5'd29: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/owik_cordic.sv @@
// Pipelined CORDIC: heading to rounded cosine and sine, command carried alongside.
`timescale 1ns / 1ps
module owik_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  owik_pkg::cmd_t  in_cmd,
  input  logic [15:0]     heading,
  output logic            out_valid,
  output owik_pkg::cmd_t  out_cmd,
  output owik_pkg::trig_t out_trig
);
  import owik_pkg::*;

  logic                 vld  [CORDIC_STEPS+1];
  logic                 flip [CORDIC_STEPS+1];
  cmd_t                 cmd  [CORDIC_STEPS+1];
  logic signed [XW-1:0] xs   [CORDIC_STEPS+1];
  logic signed [XW-1:0] ys   [CORDIC_STEPS+1];
  logic signed [ZW-1:0] zs   [CORDIC_STEPS+1];

  // fold angle into [-90, 90) degrees; flipping the top bit subtracts a half turn
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    flip[0] <= heading[15] ^ heading[14];
    cmd[0]  <= in_cmd;
    xs[0]   <= CORDIC_GAIN;
    ys[0]   <= '0;
    zs[0]   <= ZW'($signed({heading[15] ^ heading[14] ^ heading[15], heading[14:0], 16'h0}));
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      flip[i+1] <= flip[i];
      cmd[i+1]  <= cmd[i];
      if (!zs[i][ZW-1]) begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - arc_step(5'(i));
      end else begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + arc_step(5'(i));
      end
    end
  end

  // undo the fold, then round to the trig fraction width
  logic signed [XW-1:0] xf;
  logic signed [XW-1:0] yf;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;
  assign xf = flip[CORDIC_STEPS] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
  assign yf = flip[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];
  assign xr = (xf + TRIG_RND) >>> (30 - TRIG_BITS);
  assign yr = (yf + TRIG_RND) >>> (30 - TRIG_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[CORDIC_STEPS];
    end
    out_cmd     <= cmd[CORDIC_STEPS];
    out_trig.cs <= TW'(xr);
    out_trig.sn <= TW'(yr);
  end

endmodule

@@ sv/owik_wheels.sv @@
// Wheel geometry, drive sums, saturation and duty codes over five stages.
`timescale 1ns / 1ps
module owik_wheels (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  owik_pkg::cmd_t     in_cmd,
  input  owik_pkg::trig_t    in_trig,
  input  logic [15:0]        lever,
  output logic               out_valid,
  output logic signed [15:0] drive [3],
  output logic [7:0]         duty  [3]
);
  import owik_pkg::*;

  // stage 1: geometry coefficients, scaled x, lever product
  logic signed [CA_W-1:0] cx, sx;
  assign cx = CA_W'(in_trig.cs);
  assign sx = CA_W'(in_trig.sn);

  logic                   v1;
  logic signed [CA_W-1:0] ca [3];
  logic signed [CA_W-1:0] cb [3];
  logic signed [NX_W-1:0] nx;
  logic signed [15:0]     vy1;
  logic signed [LP_W-1:0] lp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    ca[0] <= (cx <<< 15) - GEO_ROOT * sx;
    cb[0] <= (sx <<< 15) + GEO_ROOT * cx;
    ca[1] <= -(cx <<< 16);
    cb[1] <= -(sx <<< 16);
    ca[2] <= (cx <<< 15) + GEO_ROOT * sx;
    cb[2] <= (sx <<< 15) - GEO_ROOT * cx;
    nx    <= -(NX_W'(in_cmd.vel_x) * NX_W'(10));
    vy1   <= in_cmd.vel_y;
    lp    <= $signed({1'b0, lever}) * LP_W'(in_cmd.spin);
  end

  // stage 2: products
  logic                   v2;
  logic signed [P1_W-1:0] p1 [3];
  logic signed [P1_W-1:0] p2 [3];
  logic signed [LP_W-1:0] lp2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int k = 0; k < 3; k++) begin
      p1[k] <= P1_W'(nx) * P1_W'(ca[k]);
      p2[k] <= P1_W'(vy1) * P1_W'(cb[k]);
    end
    lp2 <= lp;
  end

  // stage 3: sum and round once
  localparam logic signed [ACC_W-1:0] DRV_RND = ACC_W'(1) <<< (TRIG_BITS + 15);
  logic                  v3;
  logic signed [DW-1:0]  d3 [3];
  logic signed [ACC_W-1:0] acc [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = ACC_W'(p1[k]) - ACC_W'(p2[k]) + (ACC_W'(lp2) <<< (TRIG_BITS + 8)) + DRV_RND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    for (int k = 0; k < 3; k++) begin
      d3[k] <= DW'(acc[k] >>> (TRIG_BITS + 16));
    end
  end

  // stage 4: saturate, offset and clamp
  logic               v4;
  logic signed [15:0] d4 [3];
  logic [10:0]        pc [3];
  logic signed [15:0] ds [3];
  logic signed [17:0] pv [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (d3[k] > DW'(32767)) begin
        ds[k] = 16'sh7FFF;
      end else if (d3[k] < -DW'(32768)) begin
        ds[k] = -16'sh8000;
      end else begin
        ds[k] = 16'(d3[k]);
      end
      pv[k] = 18'sd1000 - 18'(ds[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    for (int k = 0; k < 3; k++) begin
      d4[k] <= ds[k];
      if (pv[k] > 18'sd1900) begin
        pc[k] <= 11'd1900;
      end else if (pv[k] < 18'sd100) begin
        pc[k] <= 11'd100;
      end else begin
        pc[k] <= 11'(pv[k]);
      end
    end
  end

  // stage 5: divide by ten through the reciprocal, exact for 100..1900
  logic [24:0] q [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q[k] = 25'(pc[k]) * 25'd6554;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v4;
    end
    for (int k = 0; k < 3; k++) begin
      drive[k] <= d4[k];
      duty[k]  <= q[k][23:16];
    end
  end

endmodule

@@ sv/omni_wheel_inverse_kinematics_top.sv @@
// Top level of the three-wheel omni drive inverse kinematics pipeline.
`timescale 1ns / 1ps
//
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+------------------------------
// command  | vel_x, vel_y, spin, heading             | start & !busy takes it
// result   | drive_one..three, duty_one..three       | done high for one cycle
// config   | wr_en, wr_data (wheel_lever)            | written when wr_en is high
//
// One transaction enters every cycle; busy is always low.
// Pipeline registers: fold, 30 CORDIC steps, trig rounding, then five
// stages of geometry, products, sum, saturation and divide.
// Reset clears the valid bits along the pipe and sets wheel_lever to 1.0.
// The receiver cannot stall, so nothing ever holds the pipe.
module omni_wheel_inverse_kinematics_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] spin,
  input  logic [15:0]        heading,
  input  logic               wr_en,
  input  logic [15:0]        wr_data,
  output logic               done,
  output logic signed [15:0] drive_one,
  output logic signed [15:0] drive_two,
  output logic signed [15:0] drive_three,
  output logic [7:0]         duty_one,
  output logic [7:0]         duty_two,
  output logic [7:0]         duty_three
);
  import owik_pkg::*;

  // lever arm register, Q8.8
  logic [15:0] wheel_lever;
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_lever <= LEVER_RESET;
    end else if (wr_en) begin
      wheel_lever <= wr_data;
    end
  end

  // never hold off a command
  assign busy = 1'b0;

  cmd_t  cmd_in;
  cmd_t  cmd_trig;
  trig_t trig;
  logic  trig_valid;
  logic signed [15:0] drive [3];
  logic [7:0]         duty  [3];

  assign cmd_in.vel_x = vel_x;
  assign cmd_in.vel_y = vel_y;
  assign cmd_in.spin  = spin;

  // rotate: cosine and sine of heading
  owik_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .in_cmd    (cmd_in),
    .heading   (heading),
    .out_valid (trig_valid),
    .out_cmd   (cmd_trig),
    .out_trig  (trig)
  );

  // apply wheel geometry and form drives and duty codes
  owik_wheels u_wheels (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trig_valid),
    .in_cmd    (cmd_trig),
    .in_trig   (trig),
    .lever     (wheel_lever),
    .out_valid (done),
    .drive     (drive),
    .duty      (duty)
  );

  assign drive_one   = drive[0];
  assign drive_two   = drive[1];
  assign drive_three = drive[2];
  assign duty_one    = duty[0];
  assign duty_two    = duty[1];
  assign duty_three  = duty[2];

endmodule

@@ verif/omni_wheel_inverse_kinematics_top_tb.sv @@
// Testbench for the three-wheel omni drive inverse kinematics pipeline.
`timescale 1ns / 1ps
module omni_wheel_inverse_kinematics_top_tb;
  import owik_pkg::*;

  localparam int LATENCY = 37;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] spin;
    logic [15:0]        heading;
  } wheel_cmd_t;

  typedef struct packed {
    logic signed [15:0] drive_one;
    logic signed [15:0] drive_two;
    logic signed [15:0] drive_three;
    logic [7:0]         duty_one;
    logic [7:0]         duty_two;
    logic [7:0]         duty_three;
  } wheel_out_t;

  logic clk, rst, start, busy, wr_en, done;
  logic signed [15:0] vel_x, vel_y, spin;
  logic [15:0] heading, wr_data;
  logic signed [15:0] drive_one, drive_two, drive_three;
  logic [7:0] duty_one, duty_two, duty_three;

  wheel_cmd_t pending_cmds[$];
  wheel_out_t expected_drives[$];
  logic [15:0] lever_q88;
  int sender_idle_pct;
  int mismatches, results_seen, cmds_sent;

  omni_wheel_inverse_kinematics_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vel_x(vel_x), .vel_y(vel_y), .spin(spin), .heading(heading),
    .wr_en(wr_en), .wr_data(wr_data), .done(done),
    .drive_one(drive_one), .drive_two(drive_two), .drive_three(drive_three),
    .duty_one(duty_one), .duty_two(duty_two), .duty_three(duty_three)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor division by a power of two, same as an arithmetic shift.
  function automatic longint floor_div_pow2(longint v, int s);
    return v >>> s;
  endfunction

  // CORDIC sin/cos of a binary angle, rounded to Q(TRIG_BITS).
  function automatic void heading_trig(input logic [15:0] hd, output longint c,
                                       output longint s);
    longint steps[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};
    logic [31:0] a;
    bit flip;
    longint x, y, z, dx, dy;
    a = {hd, 16'h0};
    flip = 0;
    x = 652032874;
    y = 0;
    if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
      a = a - 32'h8000_0000;
      flip = 1;
    end
    z = longint'($signed(a));
    for (int i = 0; i < 30; i++) begin
      dx = floor_div_pow2(y, i);
      dy = floor_div_pow2(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= steps[i];
      end else begin
        x += dx; y -= dy; z += steps[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = floor_div_pow2(x + (64'sd1 <<< (29 - TRIG_BITS)), 30 - TRIG_BITS);
    s = floor_div_pow2(y + (64'sd1 <<< (29 - TRIG_BITS)), 30 - TRIG_BITS);
  endfunction

  function automatic wheel_out_t wheel_drives(wheel_cmd_t cmd, logic [15:0] lever);
    longint ga[3] = '{32768, -65536, 32768};
    longint gb[3] = '{56756, 0, -56756};
    longint c, s, lever_term, ca, cb, acc, d, p;
    logic signed [15:0] dr[3];
    logic [7:0] du[3];
    wheel_out_t r;
    heading_trig(cmd.heading, c, s);
    lever_term = longint'(lever) * longint'(cmd.spin) * (64'sd1 <<< (TRIG_BITS + 8));
    for (int k = 0; k < 3; k++) begin
      ca = ga[k] * c - gb[k] * s;
      cb = ga[k] * s + gb[k] * c;
      acc = -(10 * longint'(cmd.vel_x)) * ca - longint'(cmd.vel_y) * cb + lever_term;
      d = floor_div_pow2(acc + (64'sd1 <<< (TRIG_BITS + 15)), TRIG_BITS + 16);
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      p = 1000 - d;
      if (p > 1900) p = 1900;
      if (p < 100) p = 100;
      dr[k] = d[15:0];
      du[k] = 8'(p / 10);
    end
    r = '{dr[0], dr[1], dr[2], du[0], du[1], du[2]};
    return r;
  endfunction

  // Driver: present the next pending command; a transaction completes when
  // start is high and busy is low at the edge.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_drives.push_back(wheel_drives({vel_x, vel_y, spin, heading}, lever_q88));
        cmds_sent++;
      end
      // Hold the current command if it was not taken yet.
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          wheel_cmd_t nc;
          nc = pending_cmds.pop_front();
          start <= 1'b1;
          vel_x <= nc.vel_x;
          vel_y <= nc.vel_y;
          spin <= nc.spin;
          heading <= nc.heading;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done cycle is one result transaction.
  always @(posedge clk) begin
    if (!rst && done) begin
      wheel_out_t got, want;
      got = '{drive_one, drive_two, drive_three, duty_one, duty_two, duty_three};
      results_seen++;
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_drives.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(200)) - 16'sd100;
      3: return 16'($urandom_range(6000)) - 16'sd3000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    while (pending_cmds.size() != 0 || start) @(posedge clk);
    @(posedge clk);
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_lever(logic [15:0] v);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en <= 1'b0;
    lever_q88 = v;
  endtask

  task automatic queue_random(int n);
    wheel_cmd_t c;
    for (int i = 0; i < n; i++) begin
      c.vel_x = rand_field();
      c.vel_y = rand_field();
      c.spin = rand_field();
      c.heading = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) << 14 : 16'($urandom);
      pending_cmds.push_back(c);
    end
  endtask

  initial begin
    logic [15:0] dir_heads[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                  16'h3FFF, 16'hBFFF, 16'hFFFF, 16'h2AAB};
    logic [15:0] levers[4] = '{16'hFFFF, 16'h0000, 16'h0180, 16'd256};
    start = 0; wr_en = 0; wr_data = 0;
    vel_x = 0; vel_y = 0; spin = 0; heading = 0;
    lever_q88 = LEVER_RESET;
    mismatches = 0; results_seen = 0; cmds_sent = 0;
    sender_idle_pct = 36;
    rst = 1;
    repeat (8) @(posedge clk);
    rst <= 0;

    // Directed: extremes, every heading quadrant, saturation and duty limits.
    foreach (dir_heads[i]) pending_cmds.push_back('{16'sh7FFF, 16'sh8000, 16'sd0, dir_heads[i]});
    pending_cmds.push_back('{16'sd0, 16'sd0, 16'sd0, 16'h0000});
    pending_cmds.push_back('{16'sd0, 16'sd0, 16'sh7FFF, 16'h1234});
    pending_cmds.push_back('{16'sd0, 16'sd0, 16'sh8000, 16'hEDCB});
    pending_cmds.push_back('{16'sd90, 16'sd0, 16'sd0, 16'h0000});
    pending_cmds.push_back('{-16'sd90, 16'sd0, 16'sd0, 16'h0000});
    pending_cmds.push_back('{16'sd0, 16'sd0, 16'sd900, 16'h0000});
    pending_cmds.push_back('{16'sd0, 16'sd0, -16'sd900, 16'h0000});
    pending_cmds.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'h8000});
    pending_cmds.push_back('{16'sh5555, 16'shAAAA, 16'sh5555, 16'hAAAA});
    pending_cmds.push_back('{16'shAAAA, 16'sh5555, 16'shAAAA, 16'h5555});
    drain();

    // Random phases with the lever swept through its extremes; the sender
    // waits for an empty pipe before each register write.
    foreach (levers[p]) begin
      write_lever(levers[p]);
      sender_idle_pct = (p == 0) ? 36 : (p == 1) ? 88 : 0;
      queue_random(p == 3 ? 365 : 355);
      drain();
    end

    $display("covered %0d commands, %0d results, lever settings 256, 0xFFFF, 0, 0x180",
             cmds_sent, results_seen);
    if (mismatches == 0 && expected_drives.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results still pending", mismatches,
               expected_drives.size());
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
sv/owik_pkg.sv
sv/owik_cordic.sv
sv/owik_wheels.sv
sv/omni_wheel_inverse_kinematics_top.sv
verif/omni_wheel_inverse_kinematics_top_tb.sv
